@@ rtl/rsas_pkg.sv @@
package rsas_pkg;

    // Position width and the "not found" code
    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_NONE = '1;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Input item
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] value;
        logic               last_element;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    overflow;
    } rsp_item_t;

    // Search engine status toward the top level
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [POS_W-1:0] position;
    } rsas_stat_t;

endpackage

@@ rtl/rotated_sorted_array_search.sv @@
// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid, req_ready | req_item_t: req_type, value, last_element
// rsp     | out | rsp_valid, rsp_ready | rsp_item_t: position, overflow
//
// A load writes the element store and produces no result.
// A search runs as a probe sequence: each probe is an issue and a compare
// step on the single registered read port, over a pivot search and up to
// two range searches.
// Reset clears the element count, the overflow flag and the response slot;
// the store itself is not cleared. req_ready is low while a search runs;
// loads are taken while a result waits in the output register.
module rotated_sorted_array_search
    import rsas_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg, count_next;
    logic               closed_reg, closed_next;
    logic               ovf_reg, ovf_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg;
    logic               req_take;
    logic               is_load;
    logic               is_search;
    logic [CW-1:0]      base_count;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               res_take;
    rsas_stat_t         stat;

    assign req_ready = !stat.busy;
    assign req_take  = req_valid && req_ready;
    assign is_load   = req_take && (req.req_type == REQ_LOAD);
    assign is_search = req_take && (req.req_type == REQ_SEARCH);

    // Load bookkeeping: a load after a closed run starts a new array
    always_comb
    begin
        count_next  = count_reg;
        closed_next = closed_reg;
        ovf_next    = ovf_reg;
        base_count  = closed_reg ? '0 : count_reg;
        wr_en       = 1'b0;
        wr_addr     = base_count[AW-1:0];
        if (is_load)
        begin
            ovf_next = closed_reg ? 1'b0 : ovf_reg;
            if (base_count < CW'(DEPTH))
            begin
                wr_en      = 1'b1;
                count_next = base_count + CW'(1);
            end
            else
            begin
                count_next = base_count;
                ovf_next   = 1'b1;
            end
            closed_next = req.last_element;
        end
        else if (is_search)
        begin
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            closed_reg <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            closed_reg <= closed_next;
            ovf_reg    <= ovf_next;
        end
    end

    rsas_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    rsas_search #(
        .CW (CW),
        .AW (AW)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (is_search),
        .target    (req.value),
        .count     (count_reg),
        .res_ready (res_take),
        .stat      (stat),
        .raddr     (rd_addr),
        .rdata     (rd_data)
    );

    // Output register
    assign res_take = stat.done && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg.position <= stat.position;
            rsp_reg.overflow <= ovf_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted search engages the engine
    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        is_search |=> stat.busy)
        else $error("search did not start");

    // Element count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // A handed-over result shows up on the output
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> rsp_valid_reg)
        else $error("result lost");

endmodule

@@ rtl/rsas_ram.sv @@
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/rsas_search.sv @@
module rsas_search
    import rsas_pkg::*;
#(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] target,
    input  logic [CW-1:0]      count,
    input  logic               res_ready,
    output rsas_stat_t         stat,
    output logic [AW-1:0]      raddr,
    input  logic signed [31:0] rdata
);

    // Signed index width: one bit above the count so that -1 fits
    localparam int IW = CW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PHI  = 7'b0000010,
        S_PISS = 7'b0000100,
        S_PCMP = 7'b0001000,
        S_RISS = 7'b0010000,
        S_RCMP = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [IW-1:0]    lo_reg, lo_next;
    logic signed [IW-1:0]    hi_reg, hi_next;
    logic signed [IW-1:0]    piv_reg, piv_next;
    logic signed [IW-1:0]    mid_reg, mid_next;
    logic signed [IW-1:0]    cnt_reg, cnt_next;
    logic signed [31:0]      hval_reg, hval_next;
    logic signed [31:0]      tgt_reg, tgt_next;
    logic                    phase_reg, phase_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [IW-1:0]    mid;
    logic signed [IW-1:0]    count_s;
    logic signed [IW-1:0]    last_idx;

    assign count_s  = $signed({1'b0, count});
    assign last_idx = count_s - IW'(1);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >>> 1);

    // Probe sequencer: pivot search, then up to two range searches
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        piv_next   = piv_reg;
        mid_next   = mid_reg;
        cnt_next   = cnt_reg;
        hval_next  = hval_reg;
        tgt_next   = tgt_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        raddr      = mid[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                raddr = last_idx[AW-1:0];
                if (start)
                begin
                    tgt_next = target;
                    cnt_next = count_s;
                    lo_next  = '0;
                    hi_next  = last_idx;
                    if (count_s == '0)
                    begin
                        pos_next   = POS_NONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PHI;
                    end
                end
            end
            S_PHI:
            begin
                hval_next  = rdata;
                state_next = S_PISS;
            end
            S_PISS:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_PCMP;
                end
                else
                begin
                    piv_next   = hi_reg;
                    lo_next    = '0;
                    hi_next    = hi_reg - IW'(1);
                    phase_next = 1'b0;
                    state_next = S_RISS;
                end
            end
            S_PCMP:
            begin
                if (rdata > hval_reg)
                begin
                    lo_next = mid_reg + IW'(1);
                end
                else
                begin
                    hi_next   = mid_reg;
                    hval_next = rdata;
                end
                state_next = S_PISS;
            end
            S_RISS:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_RCMP;
                end
                else if (!phase_reg)
                begin
                    lo_next    = piv_reg;
                    hi_next    = cnt_reg - IW'(1);
                    phase_next = 1'b1;
                end
                else
                begin
                    pos_next   = POS_NONE;
                    state_next = S_DONE;
                end
            end
            S_RCMP:
            begin
                if (rdata == tgt_reg)
                begin
                    pos_next   = POS_W'(mid_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    if (rdata < tgt_reg)
                    begin
                        lo_next = mid_reg + IW'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg - IW'(1);
                    end
                    state_next = S_RISS;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        piv_reg   <= piv_next;
        mid_reg   <= mid_next;
        cnt_reg   <= cnt_next;
        hval_reg  <= hval_next;
        tgt_reg   <= tgt_next;
        phase_reg <= phase_next;
        pos_reg   <= pos_next;
    end

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.done     = (state_reg == S_DONE);
    assign stat.position = pos_reg;

    // A pivot compare always follows its probe issue
    a_pcmp_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PCMP |-> $past(state_reg) == S_PISS)
        else $error("pivot compare without probe");

    // Pivot probe lies inside the open window
    a_pcmp_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PCMP |-> (lo_reg <= mid_reg && mid_reg < hi_reg))
        else $error("pivot probe outside window");

    // Range probes only touch loaded entries
    a_rcmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RCMP |-> (mid_reg >= 0 && mid_reg < cnt_reg))
        else $error("range probe outside loaded array");

endmodule

@@ verif/rotated_sorted_array_search_tb.sv @@
module rotated_sorted_array_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsas_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 60;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int VAL_MIN      = int'(32'h8000_0000);
    localparam int VAL_MAX      = int'(32'h7FFF_FFFF);

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    // Shared knobs between the sender and the receiver
    bit no_idle       = 1'b0;
    int rsp_hold_left = 0;
    int sent_count    = 0;
    int cycle_count   = 0;

    // Loaded array as seen by the stimulus, used only to pick search targets
    int cur_arr [$];
    bit cur_closed = 1'b1;

    rotated_sorted_array_search #(
        .DEPTH (STORE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Tracks the element store and predicts the answer of every search
    class search_scoreboard;
        logic signed [31:0] elems [STORE_DEPTH];
        int                 elem_count;
        bit                 load_closed;
        bit                 ovf_seen;
        rsp_item_t          answers_due [$];
        int                 errors;

        function new();
            elem_count  = 0;
            load_closed = 1'b1;
            ovf_seen    = 1'b0;
            errors      = 0;
        endfunction

        // Plain binary search over [lo, hi], -1 when absent
        function int find_in_range(logic signed [31:0] target, int lo, int hi);
            int mid;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (elems[mid] == target)
                    return mid;
                if (elems[mid] < target)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            return -1;
        endfunction

        // Pivot search, then the part before the pivot, then the rest
        function logic [POS_W-1:0] predict_position(logic signed [31:0] target);
            int lo;
            int hi;
            int mid;
            int pos;
            if (elem_count == 0)
                return POS_NONE;
            lo = 0;
            hi = elem_count - 1;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (elems[mid] > elems[hi])
                    lo = mid + 1;
                else
                    hi = mid;
            end
            pos = find_in_range(target, 0, hi - 1);
            if (pos < 0)
                pos = find_in_range(target, hi, elem_count - 1);
            return pos[POS_W-1:0];
        endfunction

        function void note_request(req_item_t item);
            rsp_item_t want;
            if (item.req_type == REQ_LOAD)
            begin
                // a load after a closed run starts a new array
                if (load_closed)
                begin
                    elem_count  = 0;
                    ovf_seen    = 1'b0;
                    load_closed = 1'b0;
                end
                if (elem_count < STORE_DEPTH)
                begin
                    elems[elem_count] = item.value;
                    elem_count++;
                end
                else
                    ovf_seen = 1'b1;
                if (item.last_element)
                    load_closed = 1'b1;
            end
            else
            begin
                load_closed   = 1'b1;
                want.position = predict_position(item.value);
                want.overflow = ovf_seen;
                answers_due.push_back(want);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        task log_mismatch(input string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(input rsp_item_t got);
            rsp_item_t want;
            if (answers_due.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result position %0d overflow %0b",
                                       got.position, got.overflow));
                return;
            end
            want = answers_due.pop_front();
            if (got.position !== want.position)
                log_mismatch($sformatf("position got %0d want %0d",
                                       got.position, want.position));
            if (got.overflow !== want.overflow)
                log_mismatch($sformatf("overflow got %0b want %0b",
                                       got.overflow, want.overflow));
        endtask
    endclass

    search_scoreboard sb = new();

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sorted distinct values, rotated by a random amount
    function automatic void make_rotated(input int n, input bit narrow, output int arr[$]);
        int raw [$];
        int uniq [$];
        int k;
        for (int i = 0; i < n; i++)
            raw.push_back(narrow ? int'($urandom_range(0, 60)) - 30 : int'($urandom));
        if ($urandom_range(0, 7) == 0)
        begin
            raw.push_back(VAL_MIN);
            raw.push_back(VAL_MAX);
        end
        raw.sort();
        foreach (raw[i])
            if (uniq.size() == 0 || uniq[$] != raw[i])
                uniq.push_back(raw[i]);
        k = $urandom_range(0, uniq.size() - 1);
        arr.delete();
        for (int i = 0; i < uniq.size(); i++)
            arr.push_back(uniq[(i + k) % uniq.size()]);
    endfunction

    // Offer one item and hold it until accepted; valid stays high on return
    task automatic send_item(input logic kind, input int v, input logic last);
        req_item_t item;
        int        gap;
        item.req_type     = kind;
        item.value        = v;
        item.last_element = last;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (req_ready !== 1'b1);
        sb.note_request(item);
        sent_count++;
        if (kind == REQ_LOAD)
        begin
            if (cur_closed)
            begin
                cur_arr.delete();
                cur_closed = 1'b0;
            end
            if (cur_arr.size() < STORE_DEPTH)
                cur_arr.push_back(v);
            if (last)
                cur_closed = 1'b1;
        end
        else
            cur_closed = 1'b1;
    endtask

    task automatic load_run(input int arr[$], input bit close);
        foreach (arr[i])
            send_item(REQ_LOAD, arr[i], close && (i == arr.size() - 1));
    endtask

    // Targets: mostly present, some neighbors, extremes and noise
    task automatic search_burst(input int count);
        int target;
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (cur_arr.size() > 0 && r < 65)
                target = cur_arr[$urandom_range(0, cur_arr.size() - 1)];
            else if (cur_arr.size() > 0 && r < 80)
                target = cur_arr[$urandom_range(0, cur_arr.size() - 1)] + (r[0] ? 1 : -1);
            else if (r < 90)
                target = r[0] ? VAL_MAX : VAL_MIN;
            else
                target = $urandom;
            send_item(REQ_SEARCH, target, 1'($urandom_range(0, 1)));
        end
    endtask

    // Drop valid and wait until every search has been answered
    task automatic wait_for_answers();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
                sb.check_result(rsp);
            if (rsp_hold_left > 0)
            begin
                rsp_hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ready <= 1'b0;
                end
                else
                    rsp_ready <= 1'b1;
            end
        end
    end

    // Request side
    initial
    begin
        int arr [$];
        int mode;
        int r;
        int n;
        int rand_base;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Nothing loaded yet, last flag on a search is ignored
        send_item(REQ_SEARCH, 0, 1'b0);
        send_item(REQ_SEARCH, VAL_MIN, 1'b1);
        // One-element array
        send_item(REQ_LOAD, VAL_MAX, 1'b1);
        send_item(REQ_SEARCH, VAL_MAX, 1'b0);
        send_item(REQ_SEARCH, VAL_MIN, 1'b0);
        // Extremes in a rotated array, pivot at index two
        send_item(REQ_LOAD, 5, 1'b0);
        send_item(REQ_LOAD, VAL_MAX, 1'b0);
        send_item(REQ_LOAD, VAL_MIN, 1'b0);
        send_item(REQ_LOAD, -3, 1'b1);
        send_item(REQ_SEARCH, VAL_MIN, 1'b0);
        send_item(REQ_SEARCH, VAL_MAX, 1'b0);
        send_item(REQ_SEARCH, -3, 1'b0);
        send_item(REQ_SEARCH, 5, 1'b0);
        send_item(REQ_SEARCH, 0, 1'b0);
        // Open load closed by a search, next load starts over
        send_item(REQ_LOAD, 7, 1'b0);
        send_item(REQ_LOAD, 9, 1'b0);
        send_item(REQ_SEARCH, 9, 1'b0);
        send_item(REQ_LOAD, 1, 1'b0);
        send_item(REQ_SEARCH, 7, 1'b0);
        // Repeated values
        send_item(REQ_LOAD, 3, 1'b0);
        send_item(REQ_LOAD, 3, 1'b0);
        send_item(REQ_LOAD, 3, 1'b1);
        send_item(REQ_SEARCH, 3, 1'b0);

        // Random arrays, mostly well-formed and small
        rand_base = sent_count;
        while (sent_count - rand_base < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 99) < 12);
            mode    = $urandom_range(0, 99);
            r       = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 16) :
                (r < 93) ? $urandom_range(17, 64) : $urandom_range(65, 200);
            if (mode < 72)
            begin
                make_rotated(n, $urandom_range(0, 3) == 0, arr);
                load_run(arr, $urandom_range(0, 9) != 0);
                search_burst($urandom_range(1, 6));
            end
            else if (mode < 82)
            begin
                // unsorted data, often with repeats
                arr.delete();
                repeat (n)
                    arr.push_back($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : $urandom);
                load_run(arr, 1'b1);
                search_burst($urandom_range(1, 4));
            end
            else if (mode < 90)
                search_burst($urandom_range(1, 4));
            else
            begin
                // stray last flags split the run into several arrays
                repeat (n)
                    send_item(REQ_LOAD, $urandom, $urandom_range(0, 4) == 0);
                search_burst($urandom_range(1, 3));
            end
            if ($urandom_range(0, 19) == 0)
                wait_for_answers();
        end
        no_idle = 1'b0;

        // Receiver holds off while searches keep coming
        wait_for_answers();
        rsp_hold_left = 400;
        make_rotated(10, 1'b0, arr);
        load_run(arr, 1'b1);
        search_burst(6);
        wait_for_answers();

        // Store filled past its depth: extra elements dropped, overflow set
        make_rotated(STORE_DEPTH + 3, 1'b0, arr);
        load_run(arr, 1'b1);
        search_burst(12);
        // A fresh array clears overflow again
        make_rotated(8, 1'b0, arr);
        load_run(arr, 1'b1);
        search_burst(4);

        wait_for_answers();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
